### rtl/core/clipped_sprite_blit_with_flip_assert.svh
// Assertion macros shared by the sprite blitter modules.
`ifndef CLIPPED_SPRITE_BLIT_WITH_FLIP_ASSERT_SVH
`define CLIPPED_SPRITE_BLIT_WITH_FLIP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define CSB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sprite blitter check failed");
// Next-cycle implication, checked out of reset.
`define CSB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sprite blitter check failed");
`else
`define CSB_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define CSB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/core/csb_pkg.sv
// Shared constants and types of the sprite blitter.
package csb_pkg;

  // Screen geometry.
  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int SCREEN_PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;

  // Field widths.
  localparam int ADDR_W     = 19;
  localparam int PIX_W      = 8;
  localparam int POS_W      = 11;
  localparam int SIZE_W     = 11;
  localparam int CNT_W      = 10;
  localparam int FLIP_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int MAX_SIZE   = 1024;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_COLOR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECT_COPY = 3'd6;

  // Bits of the flip mode.
  localparam int FLIP_H_BIT = 0;
  localparam int FLIP_V_BIT = 1;

  // Configuration as seen by the datapath, sizes already clamped.
  typedef struct packed {
    logic signed [POS_W-1:0] start_x;
    logic signed [POS_W-1:0] start_y;
    logic [SIZE_W-1:0]       width;
    logic [SIZE_W-1:0]       height;
    logic [FLIP_W-1:0]       flip_mode;
    logic [PIX_W-1:0]        base_color;
    logic                    direct_copy;
  } cfg_t;

  // Item held between the scan stage and the pixel stage.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [CNT_W-1:0] column;
    logic [CNT_W-1:0] row;
    logic             last;
  } scan_t;

endpackage

### rtl/core/csb_cfg.sv
// Configuration registers of the sprite blitter with size clamping.
module csb_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [csb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [csb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output csb_pkg::cfg_t                   cfg_o
);

  logic signed [csb_pkg::POS_W-1:0] start_x_q;
  logic signed [csb_pkg::POS_W-1:0] start_y_q;
  logic [csb_pkg::SIZE_W-1:0]       width_q;
  logic [csb_pkg::SIZE_W-1:0]       height_q;
  logic [csb_pkg::FLIP_W-1:0]       flip_q;
  logic [csb_pkg::PIX_W-1:0]        base_q;
  logic                             direct_q;

  // Register writes by index; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      width_q   <= csb_pkg::SIZE_W'(1);
      height_q  <= csb_pkg::SIZE_W'(1);
      flip_q    <= '0;
      base_q    <= '0;
      direct_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        csb_pkg::REG_START_X:     start_x_q <= $signed(cfg_data_i[csb_pkg::POS_W-1:0]);
        csb_pkg::REG_START_Y:     start_y_q <= $signed(cfg_data_i[csb_pkg::POS_W-1:0]);
        csb_pkg::REG_RECT_WIDTH:  width_q   <= cfg_data_i[csb_pkg::SIZE_W-1:0];
        csb_pkg::REG_RECT_HEIGHT: height_q  <= cfg_data_i[csb_pkg::SIZE_W-1:0];
        csb_pkg::REG_FLIP_MODE:   flip_q    <= cfg_data_i[csb_pkg::FLIP_W-1:0];
        csb_pkg::REG_BASE_COLOR:  base_q    <= cfg_data_i[csb_pkg::PIX_W-1:0];
        csb_pkg::REG_DIRECT_COPY: direct_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A size of zero acts as one, and anything above the maximum as the maximum.
  function automatic logic [csb_pkg::SIZE_W-1:0] clamp_size(
    input logic [csb_pkg::SIZE_W-1:0] v
  );
    logic [csb_pkg::SIZE_W-1:0] r;
    if (v == '0) begin
      r = csb_pkg::SIZE_W'(1);
    end else if (v > csb_pkg::SIZE_W'(csb_pkg::MAX_SIZE)) begin
      r = csb_pkg::SIZE_W'(csb_pkg::MAX_SIZE);
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_comb begin
    cfg_o.start_x     = start_x_q;
    cfg_o.start_y     = start_y_q;
    cfg_o.width       = clamp_size(width_q);
    cfg_o.height      = clamp_size(height_q);
    cfg_o.flip_mode   = flip_q;
    cfg_o.base_color  = base_q;
    cfg_o.direct_copy = direct_q;
  end

endmodule

### rtl/core/csb_scan.sv
// Source column and row counters and the input register stage.
`include "clipped_sprite_blit_with_flip_assert.svh"
module csb_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  csb_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  input  logic [csb_pkg::PIX_W-1:0]   src_pixel_i,
  output logic                        in_stall_o,
  input  logic                        next_free_i,
  output logic                        s1_valid_o,
  output csb_pkg::scan_t              s1_o
);

  logic [csb_pkg::CNT_W-1:0] col_q, col_d;
  logic [csb_pkg::CNT_W-1:0] row_q, row_d;
  logic                      s1_valid_q, s1_valid_d;
  csb_pkg::scan_t            s1_q;
  logic                      s1_move, s1_free, accept;
  logic                      row_end, last;

  // Handshake: the stage frees up when its item moves on to the pixel stage.
  assign s1_move    = s1_valid_q && next_free_i;
  assign s1_free    = !s1_valid_q || s1_move;
  assign in_stall_o = !s1_free;
  assign accept     = in_valid_i && s1_free;

  // A column at or past width - 1 ends the row; a row at or past height - 1 ends the sprite.
  assign row_end = ({1'b0, col_q} + csb_pkg::SIZE_W'(1)) >= cfg_i.width;
  assign last    = row_end && (({1'b0, row_q} + csb_pkg::SIZE_W'(1)) >= cfg_i.height);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + csb_pkg::CNT_W'(1);
      end else begin
        col_d = col_q + csb_pkg::CNT_W'(1);
      end
    end
  end

  assign s1_valid_d = accept || (s1_valid_q && !s1_move);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // Input register: pixel with the source place it was counted at.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.pixel  <= src_pixel_i;
      s1_q.column <= col_q;
      s1_q.row    <= row_q;
      s1_q.last   <= last;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

  // The last pixel of a sprite restarts the scan at the top-left corner.
  `CSB_ASSERT_NEXT(a_last_restarts, clk_i, rst_ni, accept && last, col_q == '0 && row_q == '0)
  // An item that cannot move on stays in the stage.
  `CSB_ASSERT_NEXT(a_s1_holds, clk_i, rst_ni, s1_valid_q && !next_free_i, s1_valid_q)

endmodule

### rtl/core/csb_pixel.sv
// Flip, offset, clip and colour key logic with the result register.
`include "clipped_sprite_blit_with_flip_assert.svh"
module csb_pixel (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  csb_pkg::cfg_t                cfg_i,
  input  logic                         s1_valid_i,
  input  csb_pkg::scan_t               s1_i,
  output logic                         next_free_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         write_enable_o,
  output logic [csb_pkg::ADDR_W-1:0]   pixel_address_o,
  output logic [csb_pkg::PIX_W-1:0]    pixel_color_o,
  output logic                         last_pixel_o
);

  // Offsets within the sprite span one bit more than the size, screen places two more.
  localparam int OFS_W = csb_pkg::SIZE_W + 1;
  localparam int SCR_W = csb_pkg::POS_W + 2;
  localparam int XI_W  = $clog2(csb_pkg::SCREEN_WIDTH + 1);
  localparam int YI_W  = $clog2(csb_pkg::SCREEN_HEIGHT + 1);

  logic signed [OFS_W-1:0]     dc, dr;
  logic signed [SCR_W-1:0]     x, y;
  logic                        on_screen, we;
  logic [csb_pkg::PIX_W-1:0]   color;
  logic [csb_pkg::ADDR_W-1:0]  addr;
  logic [XI_W-1:0]             x_idx;
  logic [YI_W-1:0]             y_idx;
  logic                        out_valid_q, out_valid_d;
  logic                        out_take, s1_move;
  logic                        we_q, last_q;
  logic [csb_pkg::ADDR_W-1:0]  addr_q;
  logic [csb_pkg::PIX_W-1:0]   color_q;

  // Mirror the source place inside the clamped sprite size.
  always_comb begin
    dc = $signed({2'b00, s1_i.column});
    dr = $signed({2'b00, s1_i.row});
    if (cfg_i.flip_mode[csb_pkg::FLIP_H_BIT]) begin
      dc = $signed({1'b0, cfg_i.width}) - OFS_W'(1) - $signed({2'b00, s1_i.column});
    end
    if (cfg_i.flip_mode[csb_pkg::FLIP_V_BIT]) begin
      dr = $signed({1'b0, cfg_i.height}) - OFS_W'(1) - $signed({2'b00, s1_i.row});
    end
  end

  // Screen place and clipping.
  assign x = SCR_W'(cfg_i.start_x) + SCR_W'(dc);
  assign y = SCR_W'(cfg_i.start_y) + SCR_W'(dr);
  assign on_screen = !x[SCR_W-1] && (x < $signed(SCR_W'(csb_pkg::SCREEN_WIDTH)))
                  && !y[SCR_W-1] && (y < $signed(SCR_W'(csb_pkg::SCREEN_HEIGHT)));

  // Colour: raw copy, or zero is transparent and others are offset by the base colour.
  always_comb begin
    we    = on_screen && (cfg_i.direct_copy || (s1_i.pixel != '0));
    color = cfg_i.direct_copy ? s1_i.pixel : (cfg_i.base_color + s1_i.pixel);
    if (!we) begin
      color = '0;
    end
  end

  // Frame-buffer address; zero when nothing is written.
  assign x_idx = x[XI_W-1:0];
  assign y_idx = y[YI_W-1:0];
  assign addr  = we ? (csb_pkg::ADDR_W'(y_idx) * csb_pkg::ADDR_W'(csb_pkg::SCREEN_WIDTH)
                       + csb_pkg::ADDR_W'(x_idx)) : '0;

  // Result register handshake.
  assign out_take    = out_valid_q && !out_stall_i;
  assign next_free_o = !out_valid_q || out_take;
  assign s1_move     = s1_valid_i && next_free_o;
  assign out_valid_d = s1_move || (out_valid_q && !out_take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      we_q    <= we;
      addr_q  <= addr;
      color_q <= color;
      last_q  <= s1_i.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_enable_o  = we_q;
  assign pixel_address_o = addr_q;
  assign pixel_color_o   = color_q;
  assign last_pixel_o    = last_q;

  // A skipped write carries neither address nor colour.
  `CSB_ASSERT_NOW(a_skip_is_zero, clk_i, rst_ni, out_valid_q && !we_q, addr_q == '0 && color_q == '0)
  // Every write lands inside the frame buffer.
  `CSB_ASSERT_NOW(a_addr_in_screen, clk_i, rst_ni, out_valid_q && we_q, addr_q < csb_pkg::ADDR_W'(csb_pkg::SCREEN_PIXELS))
  // A result that is not taken stays valid.
  `CSB_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, out_valid_q && out_stall_i, out_valid_q)

endmodule

### rtl/core/clipped_sprite_blit_with_flip.sv
// Pipeline: two register stages; a source pixel is taken into the input register,
// moves on to the result register once that is free, and stays there until taken.
// Throughput: one pixel per clock while no stall holds it; the input register and the result
// register each hold one item, so a stalled result still lets one further item in.
// Reset: asynchronous, active low; clears the registers to 0, 0, 1, 1, 0, 0, 0,
// the column and row counters to zero and both stages to empty.
module clipped_sprite_blit_with_flip (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [csb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [csb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [csb_pkg::PIX_W-1:0]       src_pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            write_enable_o,
  output logic [csb_pkg::ADDR_W-1:0]      pixel_address_o,
  output logic [csb_pkg::PIX_W-1:0]       pixel_color_o,
  output logic                            last_pixel_o
);

  csb_pkg::cfg_t  cfg;
  csb_pkg::scan_t s1;
  logic           s1_valid;
  logic           next_free;

  // Configuration registers.
  csb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Source scan and input register.
  csb_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .src_pixel_i (src_pixel_i),
    .in_stall_o  (in_stall_o),
    .next_free_i (next_free),
    .s1_valid_o  (s1_valid),
    .s1_o        (s1)
  );

  // Placement, clipping, colour and result register.
  csb_pixel u_pixel (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .s1_valid_i      (s1_valid),
    .s1_i            (s1),
    .next_free_o     (next_free),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .write_enable_o  (write_enable_o),
    .pixel_address_o (pixel_address_o),
    .pixel_color_o   (pixel_color_o),
    .last_pixel_o    (last_pixel_o)
  );

endmodule

### sim/sprite_blit_checker.sv
// Checker for the clipped sprite blitter: predicts every frame-buffer write and compares.
`timescale 1ns / 1ps

module sprite_blit_checker
  import csb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [PIX_W-1:0]      src_pixel_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  write_enable_i,
  input  logic [ADDR_W-1:0]     pixel_address_i,
  input  logic [PIX_W-1:0]      pixel_color_i,
  input  logic                  last_pixel_i,
  output int                    mismatches_o,
  output int                    pending_o
);

  localparam int REPORT_LIMIT = 10;

  // One frame-buffer write as the block presents it.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  color;
    logic              last;
  } fb_write_t;

  // Register copies as the block holds them.
  logic signed [POS_W-1:0] sprite_x;
  logic signed [POS_W-1:0] sprite_y;
  logic [SIZE_W-1:0]       sprite_w;
  logic [SIZE_W-1:0]       sprite_h;
  logic [FLIP_W-1:0]       flip;
  logic [PIX_W-1:0]        palette_base;
  logic                    raw_copy;

  // Source position of the next pixel.
  logic [CNT_W-1:0] src_col;
  logic [CNT_W-1:0] src_row;

  fb_write_t expected_writes[$];
  int        mismatches;
  int        in_flight;

  assign mismatches_o = mismatches;
  assign pending_o    = in_flight;

  // A size of zero acts as one, and anything past the maximum acts as the maximum.
  function automatic int sprite_extent(logic [SIZE_W-1:0] size);
    if (size == '0) return 1;
    if (size > MAX_SIZE) return MAX_SIZE;
    return int'(size);
  endfunction

  // Mirror the source position, place it on screen, clip it and apply the colour key.
  function automatic fb_write_t place_pixel(logic [PIX_W-1:0] pix);
    fb_write_t r;
    int w, h, dc, dr, x, y;
    w  = sprite_extent(sprite_w);
    h  = sprite_extent(sprite_h);
    dc = int'(src_col);
    dr = int'(src_row);
    if (flip[FLIP_H_BIT]) dc = w - 1 - dc;
    if (flip[FLIP_V_BIT]) dr = h - 1 - dr;
    x = sprite_x;
    y = sprite_y;
    x = x + dc;
    y = y + dr;
    r.we    = x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT;
    r.addr  = '0;
    r.color = '0;
    if (r.we) begin
      if (raw_copy) begin
        r.color = pix;
      end else if (pix == '0) begin
        r.we = 1'b0;
      end else begin
        r.color = palette_base + pix;
      end
    end
    if (r.we) r.addr = ADDR_W'(y * SCREEN_WIDTH + x);
    r.last = (int'(src_col) + 1 >= w) && (int'(src_row) + 1 >= h);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input fb_write_t want,
                                 input fb_write_t seen);
    if (mismatches < REPORT_LIMIT) begin
      $display("%0t: %s: expected we=%0d addr=%0d colour=%0d last=%0d", $time, what,
               want.we, want.addr, want.color, want.last);
      $display("%0t: %s: actual   we=%0d addr=%0d colour=%0d last=%0d", $time, what,
               seen.we, seen.addr, seen.color, seen.last);
    end
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    fb_write_t seen, want;
    int        w, h;
    logic      row_end;
    if (!rst_ni) begin
      sprite_x     = '0;
      sprite_y     = '0;
      sprite_w     = SIZE_W'(1);
      sprite_h     = SIZE_W'(1);
      flip         = '0;
      palette_base = '0;
      raw_copy     = 1'b0;
      src_col      = '0;
      src_row      = '0;
      expected_writes.delete();
      mismatches   = 0;
      in_flight   <= 0;
    end else begin
      // Register writes never touch the position counters.
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_START_X:     sprite_x     = cfg_data_i[POS_W-1:0];
          REG_START_Y:     sprite_y     = cfg_data_i[POS_W-1:0];
          REG_RECT_WIDTH:  sprite_w     = cfg_data_i[SIZE_W-1:0];
          REG_RECT_HEIGHT: sprite_h     = cfg_data_i[SIZE_W-1:0];
          REG_FLIP_MODE:   flip         = cfg_data_i[FLIP_W-1:0];
          REG_BASE_COLOR:  palette_base = cfg_data_i[PIX_W-1:0];
          REG_DIRECT_COPY: raw_copy     = cfg_data_i[0];
          default: ;
        endcase
      end

      // Compare each write leaving the block with the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        seen = {write_enable_i, pixel_address_i, pixel_color_i, last_pixel_i};
        if (expected_writes.size() == 0) begin
          report_mismatch("write with no pixel outstanding", '0, seen);
        end else begin
          want = expected_writes.pop_front();
          if (seen.we !== want.we || seen.addr !== want.addr ||
              seen.color !== want.color || seen.last !== want.last)
            report_mismatch("write differs", want, seen);
        end
      end

      // Predict the write for each accepted pixel, then step the source position.
      if (in_valid_i && !in_stall_i) begin
        expected_writes.push_back(place_pixel(src_pixel_i));
        w       = sprite_extent(sprite_w);
        h       = sprite_extent(sprite_h);
        row_end = int'(src_col) + 1 >= w;
        if (row_end && int'(src_row) + 1 >= h) begin
          src_col = '0;
          src_row = '0;
        end else if (row_end) begin
          src_col = '0;
          src_row = src_row + 1'b1;
        end else begin
          src_col = src_col + 1'b1;
        end
      end

      in_flight <= in_flight + ((in_valid_i && !in_stall_i) ? 1 : 0)
                             - ((out_valid_i && !out_stall_i) ? 1 : 0);
    end
  end

endmodule

### sim/tb_clipped_sprite_blit_with_flip.sv
// Testbench top for the clipped sprite blitter: drives pixels and settings, gives the verdict.
`timescale 1ns / 1ps

module tb_clipped_sprite_blit_with_flip;
  import csb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int RANDOM_PIXELS   = 1600;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int SETTLE_CYCLES   = 4;
  localparam int QUIET_FROM      = 700;
  localparam int QUIET_TO        = 1000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [PIX_W-1:0]      src_pixel;
  logic                  out_valid;
  logic                  out_stall;
  logic                  write_enable;
  logic [ADDR_W-1:0]     pixel_address;
  logic [PIX_W-1:0]      pixel_color;
  logic                  last_pixel;

  int   mismatch_count;
  int   pending_writes;
  int   pixels_sent;
  int   cycle_count = 0;
  logic quiet;
  logic hold_off_go;
  logic cfg_noise;

  // Clock with a 12 ns period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  clipped_sprite_blit_with_flip dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .src_pixel_i     (src_pixel),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .write_enable_o  (write_enable),
    .pixel_address_o (pixel_address),
    .pixel_color_o   (pixel_color),
    .last_pixel_o    (last_pixel)
  );

  sprite_blit_checker blit_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .src_pixel_i     (src_pixel),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .write_enable_i  (write_enable),
    .pixel_address_i (pixel_address),
    .pixel_color_i   (pixel_color),
    .last_pixel_i    (last_pixel),
    .mismatches_o    (mismatch_count),
    .pending_o       (pending_writes)
  );

  // Offer one pixel, sometimes after a short gap, and hold it until it is taken.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    if (!quiet && $urandom_range(99) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    src_pixel <= pix;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  // Narrow registers may get random bits above their width, which the block ignores.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value, input int bits);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(value);
    if (cfg_noise && bits < CFG_DATA_W) data = data | (CFG_DATA_W'($urandom) << bits);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic apply_setting(input int sx, input int sy, input int w, input int h,
                               input int flip, input int base, input int direct);
    write_reg(REG_START_X, sx, POS_W);
    write_reg(REG_START_Y, sy, POS_W);
    write_reg(REG_RECT_WIDTH, w, SIZE_W);
    write_reg(REG_RECT_HEIGHT, h, SIZE_W);
    write_reg(REG_FLIP_MODE, flip, FLIP_W);
    write_reg(REG_BASE_COLOR, base, PIX_W);
    write_reg(REG_DIRECT_COPY, direct, 1);
    cfg_we <= 1'b0;
  endtask

  // Stop offering and wait until every predicted write has come out.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_writes > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls, a quiet stretch, and one long hold-off on request.
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_stall <= !quiet && ($urandom_range(99) < 10);
    end
  end

  // Give up if the run takes far longer than any correct run could.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int first_random, phase, w, h, ew, eh, n, sx, sy;
    logic [PIX_W-1:0] pix;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    src_pixel   = '0;
    quiet       = 1'b0;
    hold_off_go = 1'b0;
    cfg_noise   = 1'b0;
    pixels_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Direct mode: zero and full-scale pixels are copied unchanged.
    apply_setting(0, 0, 3, 2, 0, 0, 1);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h01);
    send_pixel(8'h80);
    send_pixel(8'h55);
    send_pixel(8'hAA);
    settle();

    // Keyed mode, both mirrors, base colour 255; all six pixels fall below the bottom edge.
    apply_setting(-2, 478, 4, 4, 3, 255, 0);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h01);
    send_pixel(8'h80);
    send_pixel(8'h02);
    send_pixel(8'h7F);
    settle();

    // Shrink part-way through a sprite; a zero width acts as one and the
    // mirrored place falls outside the sprite.
    apply_setting(5, 5, 0, 1, 3, 16, 0);
    send_pixel(8'h10);
    send_pixel(8'h20);
    send_pixel(8'h30);
    settle();

    // Extreme start position and oversized sizes; the spare index is ignored.
    write_reg(REG_SPARE, 2047, CFG_DATA_W);
    apply_setting(-1024, 1023, 2047, 1025, 2, 128, 1);
    send_pixel(8'hC3);
    send_pixel(8'h00);
    settle();
    apply_setting(1023, -1024, 1024, 1024, 1, 1, 0);
    send_pixel(8'h3C);
    settle();

    // Bottom-right corner of the screen.
    apply_setting(638, 478, 2, 2, 0, 0, 1);
    repeat (4) send_pixel(8'($urandom_range(0, 255)));
    settle();

    // Random sprites: mostly whole small sprites, some cut short or spilling over.
    first_random = pixels_sent;
    phase        = 0;
    while (pixels_sent - first_random < RANDOM_PIXELS) begin
      quiet     = (pixels_sent - first_random >= QUIET_FROM) &&
                  (pixels_sent - first_random < QUIET_TO);
      cfg_noise = ($urandom_range(3) == 0);
      case ($urandom_range(9))
        0:       w = $urandom_range(0, 2047);
        1:       w = MAX_SIZE;
        default: w = $urandom_range(1, 12);
      endcase
      case ($urandom_range(9))
        0:       h = $urandom_range(0, 2047);
        1:       h = MAX_SIZE;
        default: h = $urandom_range(1, 12);
      endcase
      case ($urandom_range(3))
        0:       sx = $urandom_range(0, 16) - 12;
        1:       sx = SCREEN_WIDTH - 12 + $urandom_range(0, 16);
        2:       sx = $urandom_range(0, SCREEN_WIDTH - 1);
        default: sx = $urandom_range(0, 2047) - 1024;
      endcase
      case ($urandom_range(3))
        0:       sy = $urandom_range(0, 16) - 12;
        1:       sy = SCREEN_HEIGHT - 12 + $urandom_range(0, 16);
        2:       sy = $urandom_range(0, SCREEN_HEIGHT - 1);
        default: sy = $urandom_range(0, 2047) - 1024;
      endcase
      ew = (w == 0) ? 1 : ((w > MAX_SIZE) ? MAX_SIZE : w);
      eh = (h == 0) ? 1 : ((h > MAX_SIZE) ? MAX_SIZE : h);
      if (ew * eh <= 256 && $urandom_range(3) != 0) n = ew * eh * $urandom_range(1, 2);
      else n = $urandom_range(1, 150);

      apply_setting(sx, sy, w, h, $urandom_range(0, 3), $urandom_range(0, 255),
                    $urandom_range(0, 1));

      // Early on, the receiver holds off long enough for the block to fill and stall.
      if (phase == 1) begin
        n           = 150;
        hold_off_go = 1'b1;
      end

      repeat (n) begin
        case ($urandom_range(7))
          0, 1:    pix = '0;
          2:       pix = '1;
          default: pix = 8'($urandom_range(0, 255));
        endcase
        send_pixel(pix);
      end
      settle();
      phase++;
    end

    if (mismatch_count == 0 && pending_writes == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
